// ===== src/lfkj_pkg.sv =====
// ----------------------------------------------------------------------------
// lfkj_pkg - shared types and constants for the leg kinematics block
// Fixed widths, register indexes, arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lfkj_pkg;

  localparam int ANG_W  = 28;   // residual angle, 2^-24 rad
  localparam int XY_W   = 34;   // CORDIC x/y, Q2.30 plus growth
  localparam int ACC_W  = 56;   // sums at scale 2^30
  localparam int OUT_W  = 19;
  localparam int TAB_LEN = 24;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_ABAD   = 3'd0,
    REG_HIP    = 3'd1,
    REG_KNEE   = 3'd2,
    REG_OFFSET = 3'd3,
    REG_SIDE   = 3'd4
  } cfg_reg_t;

  // link geometry seen by the merge stage
  typedef struct packed {
    logic [15:0]        hip;
    logic [15:0]        knee;
    logic signed [17:0] lat;   // signed ab/ad offset
  } lfkj_geom_t;

  // one lane result, Q1.15
  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } lfkj_sc_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = (i < TAB_LEN) ? ANG_W'(28'sd65536 >>> (i - 8)) : '0;
    endcase
    return r;
  endfunction

  // Q.30 to Q1.15, round half up, saturate
  function automatic logic signed [15:0] round_sat16(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0]    t;
    logic signed [XY_W-15:0] q;
    logic signed [15:0]      r;
    t = (XY_W+1)'(v) + (XY_W+1)'(16384);
    q = t[XY_W:15];
    if (q > 32767)       r = 16'sh7FFF;
    else if (q < -32768) r = 16'sh8000;
    else                 r = q[15:0];
    return r;
  endfunction

  // scale 2^30 to output units, round half up, saturate to 19 bits
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0]    t;
    logic signed [ACC_W-30:0] q;
    logic signed [OUT_W-1:0]  r;
    t = (ACC_W+1)'(v) + (ACC_W+1)'(64'sd536870912);
    q = t[ACC_W:30];
    if (q > 262143)       r = 19'sh3FFFF;
    else if (q < -262144) r = 19'sh40000;
    else                  r = q[OUT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/lfkj_cordic.sv =====
// ----------------------------------------------------------------------------
// lfkj_cordic - pipelined rotation-mode CORDIC lane
// One stage per iteration; folds the angle into +-pi/2 and rounds to Q1.15.
// Registered fold, micro-rotation and rounding stages; one angle per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfkj_cordic #(
  parameter int STEPS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire logic signed [15:0] angle,
  output logic                out_valid,
  output lfkj_pkg::lfkj_sc_t  result
);
  import lfkj_pkg::*;

  logic                    vld [0:STEPS];
  logic                    flp [0:STEPS];
  logic signed [ANG_W-1:0] ang [0:STEPS];
  logic signed [XY_W-1:0]  xr  [0:STEPS];
  logic signed [XY_W-1:0]  yr  [0:STEPS];

  // angle scaling and quadrant fold
  logic signed [ANG_W-1:0] a_ext;
  assign a_ext = ANG_W'(angle) <<< 11;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
    xr[0] <= CORDIC_GAIN;
    yr[0] <= '0;
    if (a_ext > ANG_HALF_PI) begin
      ang[0] <= a_ext - ANG_PI;
      flp[0] <= 1'b1;
    end else if (a_ext < -ANG_HALF_PI) begin
      ang[0] <= a_ext + ANG_PI;
      flp[0] <= 1'b1;
    end else begin
      ang[0] <= a_ext;
      flp[0] <= 1'b0;
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] ATN = atan_entry(i);
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
      flp[i+1] <= flp[i];
      if (!ang[i][ANG_W-1]) begin
        xr[i+1]  <= xr[i] - (yr[i] >>> i);
        yr[i+1]  <= yr[i] + (xr[i] >>> i);
        ang[i+1] <= ang[i] - ATN;
      end else begin
        xr[i+1]  <= xr[i] + (yr[i] >>> i);
        yr[i+1]  <= yr[i] - (xr[i] >>> i);
        ang[i+1] <= ang[i] + ATN;
      end
    end
  end

  // sign fix and rounding
  logic signed [XY_W-1:0] xf, yf;
  assign xf = flp[STEPS] ? -xr[STEPS] : xr[STEPS];
  assign yf = flp[STEPS] ? -yr[STEPS] : yr[STEPS];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vld[STEPS];
    result.c <= round_sat16(xf);
    result.s <= round_sat16(yf);
  end

endmodule

`default_nettype wire

// ===== src/lfkj_merge.sv =====
// ----------------------------------------------------------------------------
// lfkj_merge - combines the three lane results into position and Jacobian
// Seven pipeline stages, one multiply or one add level each.
// ----------------------------------------------------------------------------
`default_nettype none

module lfkj_merge (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire lfkj_pkg::lfkj_sc_t   sc1,
  input  wire lfkj_pkg::lfkj_sc_t   sc2,
  input  wire lfkj_pkg::lfkj_sc_t   sc3,
  input  wire lfkj_pkg::lfkj_geom_t geom,
  output logic                out_valid,
  output logic signed [18:0]  foot_x,
  output logic signed [18:0]  foot_y,
  output logic signed [18:0]  foot_z,
  output logic signed [18:0]  jac_01,
  output logic signed [18:0]  jac_02,
  output logic signed [18:0]  jac_10,
  output logic signed [18:0]  jac_11,
  output logic signed [18:0]  jac_12,
  output logic signed [18:0]  jac_20,
  output logic signed [18:0]  jac_21,
  output logic signed [18:0]  jac_22
);
  import lfkj_pkg::*;

  logic [5:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[4:0], in_valid};
      out_valid <= vld[5];
    end
  end

  // stage A: angle-sum products
  logic signed [31:0] cc_a, ss_a, sc_a, cs_a;
  logic signed [15:0] s1_a, c1_a, s2_a, c2_a;
  lfkj_geom_t         g_a;
  always_ff @(posedge clk) begin
    cc_a <= sc2.c * sc3.c;
    ss_a <= sc2.s * sc3.s;
    sc_a <= sc2.s * sc3.c;
    cs_a <= sc2.c * sc3.s;
    s1_a <= sc1.s; c1_a <= sc1.c; s2_a <= sc2.s; c2_a <= sc2.c;
    g_a  <= geom;
  end

  // stage B: c23, s23 rounded to Q.15
  logic signed [33:0] c23_sum, s23_sum;
  assign c23_sum = 34'(cc_a) - 34'(ss_a) + 34'sd16384;
  assign s23_sum = 34'(sc_a) + 34'(cs_a) + 34'sd16384;

  logic signed [17:0] c23_b, s23_b;
  logic signed [15:0] s1_b, c1_b, s2_b, c2_b;
  lfkj_geom_t         g_b;
  always_ff @(posedge clk) begin
    c23_b <= c23_sum[32:15];
    s23_b <= s23_sum[32:15];
    s1_b <= s1_a; c1_b <= c1_a; s2_b <= s2_a; c2_b <= c2_a;
    g_b  <= g_a;
  end

  // stage C: link length products
  logic signed [34:0] l3c_c, l3s_c;
  logic signed [32:0] l2c_c, l2s_c;
  logic signed [33:0] ls1_c, lc1_c;
  logic signed [15:0] s1_c, c1_c;
  always_ff @(posedge clk) begin
    l3c_c <= $signed({1'b0, g_b.knee}) * c23_b;
    l3s_c <= $signed({1'b0, g_b.knee}) * s23_b;
    l2c_c <= $signed({1'b0, g_b.hip}) * c2_b;
    l2s_c <= $signed({1'b0, g_b.hip}) * s2_b;
    ls1_c <= g_b.lat * s1_b;
    lc1_c <= g_b.lat * c1_b;
    s1_c <= s1_b; c1_c <= c1_b;
  end

  // stage D: planar sums
  logic signed [36:0] p_d, q_d;
  logic signed [34:0] l3c_d, l3s_d;
  logic signed [33:0] ls1_d, lc1_d;
  logic signed [15:0] s1_d, c1_d;
  always_ff @(posedge clk) begin
    p_d <= 37'(l3c_c) + 37'(l2c_c);
    q_d <= 37'(l3s_c) + 37'(l2s_c);
    l3c_d <= l3c_c; l3s_d <= l3s_c;
    ls1_d <= ls1_c; lc1_d <= lc1_c;
    s1_d <= s1_c; c1_d <= c1_c;
  end

  // stage E: ab/ad rotation products
  logic signed [52:0] cp_e, sp_e, sq_e, cq_e;
  logic signed [50:0] sl3_e, cl3_e;
  logic signed [36:0] p_e, q_e;
  logic signed [34:0] l3c_e;
  logic signed [33:0] ls1_e, lc1_e;
  always_ff @(posedge clk) begin
    cp_e  <= c1_d * p_d;
    sp_e  <= s1_d * p_d;
    sq_e  <= s1_d * q_d;
    cq_e  <= c1_d * q_d;
    sl3_e <= s1_d * l3s_d;
    cl3_e <= c1_d * l3s_d;
    p_e <= p_d; q_e <= q_d; l3c_e <= l3c_d;
    ls1_e <= ls1_d; lc1_e <= lc1_d;
  end

  // stage F: sums at scale 2^30
  logic signed [ACC_W-1:0] j10_f, j20_f, x_f, z_f, j02_f, j11_f, j12_f, j21_f, j22_f;
  always_ff @(posedge clk) begin
    j10_f <= ACC_W'(cp_e) - (ACC_W'(ls1_e) <<< 15);
    j20_f <= ACC_W'(sp_e) + (ACC_W'(lc1_e) <<< 15);
    x_f   <= ACC_W'(q_e) <<< 15;
    z_f   <= ACC_W'(p_e) <<< 15;
    j02_f <= ACC_W'(l3c_e) <<< 15;
    j11_f <= -ACC_W'(sq_e);
    j12_f <= -ACC_W'(sl3_e);
    j21_f <= ACC_W'(cq_e);
    j22_f <= ACC_W'(cl3_e);
  end

  // stage G: round and saturate into output registers
  always_ff @(posedge clk) begin
    foot_x <= finish(x_f);
    foot_y <= finish(j20_f);
    foot_z <= finish(-j10_f);
    jac_01 <= finish(z_f);
    jac_02 <= finish(j02_f);
    jac_10 <= finish(j10_f);
    jac_11 <= finish(j11_f);
    jac_12 <= finish(j12_f);
    jac_20 <= finish(j20_f);
    jac_21 <= finish(j21_f);
    jac_22 <= finish(j22_f);
  end

endmodule

`default_nettype wire

// ===== src/leg_forward_kinematics_jacobian.sv =====
// ----------------------------------------------------------------------------
// leg_forward_kinematics_jacobian - three-joint leg position and Jacobian
// Three CORDIC lanes form sine/cosine of each joint; a merge pipeline forms
// the foot position and eight Jacobian entries.
//
//   channel  signals                               transfer
//   input    start, busy, leg_index, angle_*       start && !busy
//   result   done, foot_*, jac_*                   done (one cycle)
//   config   cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//
// One item accepted every cycle; busy stays low.
// Each item passes through the CORDIC lane stages, then seven merge stages.
// Reset clears the pipeline valid bits and loads the register defaults.
// Results cannot be stalled; each appears for one cycle with done.
// ----------------------------------------------------------------------------
`default_nettype none

module leg_forward_kinematics_jacobian #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         leg_index,
  input  wire  logic signed [15:0] angle_abad,
  input  wire  logic signed [15:0] angle_hip,
  input  wire  logic signed [15:0] angle_knee,
  output logic               done,
  output logic signed [18:0] foot_x,
  output logic signed [18:0] foot_y,
  output logic signed [18:0] foot_z,
  output logic signed [18:0] jac_01,
  output logic signed [18:0] jac_02,
  output logic signed [18:0] jac_10,
  output logic signed [18:0] jac_11,
  output logic signed [18:0] jac_12,
  output logic signed [18:0] jac_20,
  output logic signed [18:0] jac_21,
  output logic signed [18:0] jac_22,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [15:0]        cfg_data
);
  import lfkj_pkg::*;

  localparam int LANE_LAT = CORDIC_STEPS + 2;
  localparam int TOT_LAT  = LANE_LAT + 7;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [15:0] abad_link_length, hip_link_length, knee_link_length, knee_lateral_offset;
  logic [3:0]  side_sign_mask;
  always_ff @(posedge clk) begin
    if (rst) begin
      abad_link_length    <= '0;
      hip_link_length     <= '0;
      knee_link_length    <= '0;
      knee_lateral_offset <= '0;
      side_sign_mask      <= 4'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ABAD:   abad_link_length    <= cfg_data;
        REG_HIP:    hip_link_length     <= cfg_data;
        REG_KNEE:   knee_link_length    <= cfg_data;
        REG_OFFSET: knee_lateral_offset <= cfg_data;
        REG_SIDE:   side_sign_mask      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // signed lateral offset per item, delayed alongside the lanes
  logic               in_xfer;
  logic [16:0]        lat_mag;
  logic signed [17:0] lat_in;
  assign in_xfer = start && !busy;
  assign lat_mag = 17'(abad_link_length) + 17'(knee_lateral_offset);
  assign lat_in  = side_sign_mask[leg_index] ? $signed({1'b0, lat_mag})
                                             : -$signed({1'b0, lat_mag});

  logic signed [17:0] lat_dly [0:LANE_LAT-1];
  always_ff @(posedge clk) begin
    lat_dly[0] <= lat_in;
    for (int k = 1; k < LANE_LAT; k++) lat_dly[k] <= lat_dly[k-1];
  end

  // three CORDIC lanes
  logic     v1, v2, v3;
  lfkj_sc_t sc1, sc2, sc3;
  lfkj_cordic #(.STEPS(CORDIC_STEPS)) u_lane_abad (
    .clk(clk), .rst(rst), .in_valid(in_xfer), .angle(angle_abad),
    .out_valid(v1), .result(sc1));
  lfkj_cordic #(.STEPS(CORDIC_STEPS)) u_lane_hip (
    .clk(clk), .rst(rst), .in_valid(in_xfer), .angle(angle_hip),
    .out_valid(v2), .result(sc2));
  lfkj_cordic #(.STEPS(CORDIC_STEPS)) u_lane_knee (
    .clk(clk), .rst(rst), .in_valid(in_xfer), .angle(angle_knee),
    .out_valid(v3), .result(sc3));

  lfkj_geom_t geom;
  assign geom.hip  = hip_link_length;
  assign geom.knee = knee_link_length;
  assign geom.lat  = lat_dly[LANE_LAT-1];

  lfkj_merge u_merge (
    .clk(clk), .rst(rst), .in_valid(v1),
    .sc1(sc1), .sc2(sc2), .sc3(sc3), .geom(geom),
    .out_valid(done),
    .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z),
    .jac_01(jac_01), .jac_02(jac_02), .jac_10(jac_10), .jac_11(jac_11),
    .jac_12(jac_12), .jac_20(jac_20), .jac_21(jac_21), .jac_22(jac_22));

  // lanes run in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (v1 == v2) && (v2 == v3)) else $error("CORDIC lanes out of step");

  // every result traces back to an accepted item
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_xfer, TOT_LAT)) else $error("result without item");

  // a lane result always reaches the output
  a_lane_to_done: assert property (@(posedge clk) disable iff (rst)
    v1 |-> ##7 (done || rst)) else $error("lane result lost");

endmodule

`default_nettype wire

// ===== dv/leg_forward_kinematics_jacobian_tb.sv =====
// ----------------------------------------------------------------------------
// leg_forward_kinematics_jacobian_tb - leg position and Jacobian checker
// Drives joint angle sets through the command port, predicts the foot
// position and Jacobian entries with a bit-exact fixed-point model and
// compares every result in order. Geometry registers change between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module leg_forward_kinematics_jacobian_tb;
  import lfkj_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 9;

  typedef struct {
    logic signed [18:0] f[11];
  } kin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] leg_index = '0;
  logic signed [15:0] angle_abad = '0, angle_hip = '0, angle_knee = '0;
  logic done;
  logic signed [18:0] foot_x, foot_y, foot_z, jac_01, jac_02, jac_10, jac_11,
    jac_12, jac_20, jac_21, jac_22;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor copy of the registers
  longint geo_abad, geo_hip, geo_knee, geo_offset, geo_side;
  kin_result_t pending_q[$];
  int errors = 0;
  int idle_pct = 31;

  always #6 clk = ~clk;

  leg_forward_kinematics_jacobian #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk, .rst, .start, .busy, .leg_index, .angle_abad, .angle_hip, .angle_knee,
    .done, .foot_x, .foot_y, .foot_z, .jac_01, .jac_02, .jac_10, .jac_11,
    .jac_12, .jac_20, .jac_21, .jac_22, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data
  );

  function automatic longint fdiv(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v - 1) >>> s) - 1;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint q30_to_q15(longint v);
    return fdiv(v + 16384, 15);
  endfunction

  function automatic longint atan_val(int i);
    longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                     262123, 131069};
    if (i < 8) return t[i];
    return longint'(65536) >>> (i - 8);
  endfunction

  // rotation CORDIC with pi fold, outputs Q1.15
  task automatic sincos(input logic signed [15:0] ang, output longint s,
                        output longint c);
    longint a, x, y, nx, ny;
    bit flip;
    a = longint'(ang) * 2048;
    x = 652032874;
    y = 0;
    flip = 0;
    if (a > 26353589) begin
      a -= 52707179; flip = 1;
    end else if (a < -26353589) begin
      a += 52707179; flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (a >= 0) begin
        nx = x - fdiv(y, i); ny = y + fdiv(x, i); a -= atan_val(i);
      end else begin
        nx = x + fdiv(y, i); ny = y - fdiv(x, i); a += atan_val(i);
      end
      x = nx; y = ny;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(q30_to_q15(x), -32768, 32767);
    s = clip(q30_to_q15(y), -32768, 32767);
  endtask

  function automatic logic signed [18:0] to_units(longint v);
    return 19'(clip(fdiv(v + (longint'(1) << 29), 30), -262144, 262143));
  endfunction

  task automatic predict_leg(input logic [1:0] leg, input logic signed [15:0] a1,
                             input logic signed [15:0] a2,
                             input logic signed [15:0] a3);
    longint s1, c1, s2, c2, s3, c3, c23, s23, lat, j10, j20;
    kin_result_t r;
    lat = geo_abad + geo_offset;
    if (((geo_side >> leg) & 1) == 0) lat = -lat;
    sincos(a1, s1, c1);
    sincos(a2, s2, c2);
    sincos(a3, s3, c3);
    c23 = q30_to_q15(c2 * c3 - s2 * s3);
    s23 = q30_to_q15(s2 * c3 + c2 * s3);
    j10 = geo_knee * c1 * c23 + geo_hip * c1 * c2 - lat * s1 * 32768;
    j20 = geo_knee * s1 * c23 + geo_hip * c2 * s1 + lat * c1 * 32768;
    r.f[0] = to_units((geo_knee * s23 + geo_hip * s2) * 32768);
    r.f[1] = to_units(j20);
    r.f[2] = to_units(-j10);
    r.f[3] = to_units((geo_knee * c23 + geo_hip * c2) * 32768);
    r.f[4] = to_units(geo_knee * c23 * 32768);
    r.f[5] = to_units(j10);
    r.f[6] = to_units(-(geo_knee * s1 * s23) - geo_hip * s1 * s2);
    r.f[7] = to_units(-(geo_knee * s1 * s23));
    r.f[8] = to_units(j20);
    r.f[9] = to_units(geo_knee * c1 * s23 + geo_hip * c1 * s2);
    r.f[10] = to_units(geo_knee * c1 * s23);
    pending_q.insert(pending_q.size(), r);
  endtask

  // result checker: one transfer per done cycle
  always @(posedge clk) begin
    kin_result_t want;
    logic signed [18:0] got[11];
    if (!rst && done) begin
      got = '{foot_x, foot_y, foot_z, jac_01, jac_02, jac_10, jac_11, jac_12,
              jac_20, jac_21, jac_22};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual foot_x %0d",
                 $time, foot_x);
        errors++;
      end else begin
        want = pending_q.pop_front();
        for (int k = 0; k < 11; k++)
          if (got[k] !== want.f[k]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, k,
                     want.f[k], got[k]);
            errors++;
          end
      end
    end
  end

  // send one angle set; holds start across back-to-back transfers
  task automatic send_leg(input logic [1:0] leg, input logic signed [15:0] a1,
                          input logic signed [15:0] a2,
                          input logic signed [15:0] a3);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    leg_index <= leg;
    angle_abad <= a1;
    angle_hip <= a2;
    angle_knee <= a3;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_leg(leg, a1, a2, a3);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ABAD:   geo_abad = val;
      REG_HIP:    geo_hip = val;
      REG_KNEE:   geo_knee = val;
      REG_OFFSET: geo_offset = val;
      REG_SIDE:   geo_side = val & 4'hF;
      default: ;
    endcase
  endtask

  // geometry changes only with the pipeline empty and start low
  task automatic set_geometry(input logic [15:0] ab, hp, kn, off,
                              input logic [3:0] side);
    drain();
    write_reg(REG_ABAD, ab);
    write_reg(REG_HIP, hp);
    write_reg(REG_KNEE, kn);
    write_reg(REG_OFFSET, off);
    write_reg(REG_SIDE, {12'h0, side});
  endtask

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(51472)) - 25736);
  endfunction

  // extremes, zero, pi fold boundaries, every leg with reset geometry
  task automatic test_directed;
    logic signed [15:0] edges[8] = '{16'sd0, 16'sd25736, -16'sd25736,
      16'sd12868, -16'sd12869, 16'sh7FFF, 16'sh8000, 16'sd12869};
    for (int l = 0; l < 4; l++) send_leg(2'(l), 16'sd0, 16'sd0, 16'sd0);
    set_geometry(16'd5000, 16'd13500, 16'd13500, 16'd3000, 4'b1010);
    for (int i = 0; i < 8; i++)
      send_leg(2'(i), edges[i], edges[7 - i], edges[(i + 3) % 8]);
    drain();
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0101);
    for (int i = 0; i < 8; i++)
      send_leg(2'(i), edges[(i + 5) % 8], edges[i], edges[7 - i]);
    drain();
  endtask

  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++)
      send_leg(2'($urandom), rand_angle(), rand_angle(), rand_angle());
    drain();
  endtask

  task automatic test_geometry_sweep;
    set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 4'b0000);
    test_random(40, 31);
    set_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 4'($urandom));
    test_random(300, 31);
    set_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 4'b1111);
    test_random(300, 61);
    set_geometry(16'd6000, 16'd14000, 16'd14000, 16'd2500, 4'($urandom));
    test_random(300, 0);
  endtask

  initial begin
    geo_abad = 0; geo_hip = 0; geo_knee = 0; geo_offset = 0; geo_side = 10;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_geometry_sweep();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/lfkj_pkg.sv
src/lfkj_cordic.sv
src/lfkj_merge.sv
src/leg_forward_kinematics_jacobian.sv
dv/leg_forward_kinematics_jacobian_tb.sv
